FILE: hdl/hvt_pkg.sv
// Shared types and constants for the homogeneous vertex transform.
package hvt_pkg;

  localparam int DATA_W = 32;
  localparam int DIM    = 4;
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 3;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_VEC4  = 2'd1,
    OP_DIR   = 2'd2,
    OP_POINT = 2'd3
  } op_t;

  // Per-stage load enables shared by all row lanes.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

FILE: hdl/hvt_if.sv
// Handshake channels for vertex words in and transformed words out.
interface hvt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  coef_index;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic signed [31:0] in_w;

  modport source (output valid, op, coef_index, in_x, in_y, in_z, in_w, input ready);
  modport sink (input valid, op, coef_index, in_x, in_y, in_z, in_w, output ready);
endinterface

interface hvt_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

FILE: hdl/hvt_lane.sv
// One matrix row dotted with the vector: multiply, pair add, round and saturate.
module hvt_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  hvt_pkg::stage_en_t                en,
  input  logic signed [hvt_pkg::DATA_W-1:0] coef [hvt_pkg::DIM],
  input  logic signed [hvt_pkg::DATA_W-1:0] vec [hvt_pkg::DIM],
  output logic signed [hvt_pkg::DATA_W-1:0] result
);
  import hvt_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] POS_MAX = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] NEG_MIN = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]  total;
  logic signed [SUM_W-1:0]  scaled;
  logic signed [DATA_W-1:0] sat;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < DIM; c++) begin
        prod[c] <= PROD_W'(coef[c]) * PROD_W'(vec[c]);
      end
    end
    if (en.s2) begin
      pair[0] <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair[1] <= PAIR_W'(prod[2]) + PAIR_W'(prod[3]);
    end
    if (en.s3) begin
      result <= sat;
    end
  end

  // Adding half an LSB before the arithmetic shift rounds half toward plus infinity.
  always_comb begin
    total  = SUM_W'(pair[0]) + SUM_W'(pair[1]) + HALF;
    scaled = total >>> FRAC_BITS;
    if (scaled > POS_MAX) begin
      sat = POS_MAX[DATA_W-1:0];
    end else if (scaled < NEG_MIN) begin
      sat = NEG_MIN[DATA_W-1:0];
    end else begin
      sat = scaled[DATA_W-1:0];
    end
  end

endmodule

FILE: hdl/hvt_merge.sv
// Output register that gathers the four lane results into one word.
module hvt_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              lane_valid,
  input  logic signed [hvt_pkg::DATA_W-1:0] lane_res [hvt_pkg::DIM],
  output logic                              take,
  hvt_out_if.source                         result
);
  import hvt_pkg::*;

  logic valid;

  assign take         = !valid || result.ready;
  assign result.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && lane_valid) begin
      result.out_x <= lane_res[0];
      result.out_y <= lane_res[1];
      result.out_z <= lane_res[2];
      result.out_w <= lane_res[3];
    end
  end

endmodule

FILE: hdl/homogeneous_vertex_transform.sv
// 4x4 matrix times homogeneous vector in signed fixed point, four row lanes.
// A transform word passes the product, pair-sum, lane and output registers to result.
// Throughput: a word per cycle unless stalled; 16 32x32 multipliers, one per coefficient.
// Load words update the matrix at acceptance and produce no output.
// Reset (synchronous): matrix returns to identity and the pipeline empties.
module homogeneous_vertex_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  hvt_in_if.sink    vertex,
  hvt_out_if.source result
);
  import hvt_pkg::*;

  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic signed [DATA_W-1:0] matrix [DIM*DIM];
  logic signed [DATA_W-1:0] row_coef [DIM][DIM];
  logic signed [DATA_W-1:0] vec [DIM];
  logic signed [DATA_W-1:0] lane_res [DIM];
  logic signed [DATA_W-1:0] w_sel;

  logic      v1, v2, v3;
  logic      ready1, ready2, ready3;
  logic      take;
  logic      accept;
  logic      is_load;
  stage_en_t en;

  assign is_load      = (vertex.op == OP_LOAD);
  assign accept       = vertex.valid && vertex.ready;
  assign ready3       = !v3 || take;
  assign ready2       = !v2 || ready3;
  assign ready1       = !v1 || ready2;
  assign vertex.ready = ready1;
  assign en           = '{s1: ready1, s2: ready2, s3: ready3};

  always_comb begin
    case (vertex.op)
      OP_VEC4:  w_sel = vertex.in_w;
      OP_DIR:   w_sel = '0;
      OP_POINT: w_sel = ONE;
      default:  w_sel = '0;
    endcase
  end

  assign vec[0] = vertex.in_x;
  assign vec[1] = vertex.in_y;
  assign vec[2] = vertex.in_z;
  assign vec[3] = w_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIM*DIM; i++) begin
        matrix[i] <= (i % (DIM + 1) == 0) ? ONE : '0;
      end
    end else if (accept && is_load) begin
      matrix[vertex.coef_index] <= vertex.in_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= accept && !is_load;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    for (genvar c = 0; c < DIM; c++) begin : g_coef
      assign row_coef[r][c] = matrix[r*DIM + c];
    end

    hvt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .coef  (row_coef[r]),
      .vec   (vec),
      .result(lane_res[r])
    );
  end

  hvt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lane_valid(v3),
    .lane_res  (lane_res),
    .take      (take),
    .result    (result)
  );

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && is_load |=> !v1)
    else $error("load word entered the transform pipeline");

  a_xform_enters: assert property (@(posedge clk) disable iff (rst)
    accept && !is_load |=> v1)
    else $error("transform word was lost at acceptance");

  a_load_writes: assert property (@(posedge clk) disable iff (rst)
    accept && is_load |=> matrix[$past(vertex.coef_index)] == $past(vertex.in_x))
    else $error("coefficient load did not reach the matrix");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v3 && !take |=> v3 && $stable(lane_res[0]) && $stable(lane_res[3]))
    else $error("last lane stage changed while the output was stalled");

endmodule
